### design/bpfc_pkg.sv
// ----------------------------------------------------------------------------
// bpfc_pkg
// Shared constants for the bit pattern frequency counter: field widths,
// beat layout codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bpfc_pkg;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

    // input beat fields
    localparam int QLEN_W     = 4;
    localparam int QPAT_W     = 12;
    localparam int IN_TDATA_W = 24;
    localparam int IN_TUSER_W = 1;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // output beat
    localparam int OUT_TDATA_W = 32;

    typedef logic [CFG_W-1:0] t_len_cfg;

endpackage

### design/bit_pattern_frequency_counter.sv
// ----------------------------------------------------------------------------
// bit_pattern_frequency_counter
// Counts every overlapping bit pattern of a configured length range in a
// serial bit stream; counts live in one RAM, updated read-modify-write.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2^(MAX_PATTERN_LEN+1) count RAM entries
// (8192 by default) to zero, one entry a cycle; no beat is taken in that
// time, configuration writes are. A push beat (tuser mode 0) is accepted in
// the idle state and then counts n lengths, where n is the number counted
// for that bit (at most MAX_PATTERN_LEN), in an update state: the single
// RAM read port issues one length per cycle while the write port retires
// the previous one, and a tail state retires the last write; a push that
// counts no length is done once accepted. A read beat (mode 1) reads the
// RAM on acceptance, taking the registered data in a query state; its count
// then waits in the output register until taken; no further beat of either
// kind is accepted while it waits, except in the cycle in which it is taken.
// ----------------------------------------------------------------------------
module bit_pattern_frequency_counter #(
    parameter int MAX_PATTERN_LEN = 12,
    parameter int COUNT_WIDTH     = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bpfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpfc_pkg::CFG_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: [0] stream_bit, [4:1] query_len, [16:5] query_pattern, rest zero
    input  logic [bpfc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: [0] mode
    input  logic [bpfc_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: [31:0] pattern_count
    output logic [bpfc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    import bpfc_pkg::*;

    localparam int ADDR_W = MAX_PATTERN_LEN + 1;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int HIST_W = MAX_PATTERN_LEN;
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    localparam logic [CMP_W-1:0] MAX_LEN_C = CMP_W'(MAX_PATTERN_LEN);
    localparam logic [LEN_W-1:0] SEEN_MAX  = LEN_W'(MAX_PATTERN_LEN);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_TAIL  = 3'd3;
    localparam logic [2:0] ST_QRD   = 3'd4;

    // table index: sentinel one at bit len, pattern bits below it
    function automatic logic [ADDR_W-1:0] f_addr(input logic [LEN_W-1:0]  len,
                                                 input logic [HIST_W-1:0] bits);
        logic [ADDR_W-1:0] ext;
        logic [ADDR_W-1:0] a;
        ext = ADDR_W'(bits);
        for (int i = 0; i < ADDR_W; i++) begin
            if (i == int'(len)) begin
                a[i] = 1'b1;
            end else if (i < int'(len)) begin
                a[i] = ext[i];
            end else begin
                a[i] = 1'b0;
            end
        end
        return a;
    endfunction

    // input fields
    logic              s_mode;
    logic              s_bit;
    logic [QLEN_W-1:0] s_qlen;
    logic [QPAT_W-1:0] s_qpat;

    assign s_mode = i_s_axis_tuser[0];
    assign s_bit  = i_s_axis_tdata[0];
    assign s_qlen = i_s_axis_tdata[QLEN_W:1];
    assign s_qpat = i_s_axis_tdata[QLEN_W+QPAT_W:QLEN_W+1];

    // registers
    logic [2:0]             r_state,    n_state;
    t_len_cfg               r_min_len,  n_min_len;
    t_len_cfg               r_max_len,  n_max_len;
    logic [HIST_W-1:0]      r_hist,     n_hist;
    logic [LEN_W-1:0]       r_seen,     n_seen;
    logic [LEN_W-1:0]       r_rd_len,   n_rd_len;
    logic [LEN_W-1:0]       r_hi,       n_hi;
    logic                   r_wr_pend,  n_wr_pend;
    logic [ADDR_W-1:0]      r_wr_addr,  n_wr_addr;
    logic [ADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic                   r_q_bad,    n_q_bad;
    logic                   r_out_vld,  n_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // RAM ports
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    logic              in_fire;
    logic [LEN_W-1:0]  seen_nx;
    logic [HIST_W-1:0] hist_nx;
    logic [CMP_W-1:0]  lo_c;
    logic [CMP_W-1:0]  hi_c;
    logic [CMP_W-1:0]  max_c;
    logic [CMP_W-1:0]  seen_c;
    logic [CMP_W-1:0]  qlen_c;
    logic [ADDR_W-1:0] upd_addr;

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_axis_tready);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    assign hist_nx  = HIST_W'({r_hist, s_bit});
    assign seen_nx  = (r_seen == SEEN_MAX) ? r_seen : r_seen + LEN_W'(1);
    assign seen_c   = CMP_W'(seen_nx);
    assign max_c    = CMP_W'(r_max_len);
    assign lo_c     = (r_min_len == '0) ? CMP_W'(1) : CMP_W'(r_min_len);
    assign hi_c     = (max_c < seen_c) ? max_c : seen_c;
    assign qlen_c   = CMP_W'(s_qlen);
    assign upd_addr = f_addr(r_rd_len, r_hist);

    // saturating increment
    assign cnt_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);

    always_comb begin
        n_state    = r_state;
        n_min_len  = r_min_len;
        n_max_len  = r_max_len;
        n_hist     = r_hist;
        n_seen     = r_seen;
        n_rd_len   = r_rd_len;
        n_hi       = r_hi;
        n_wr_pend  = 1'b0;
        n_wr_addr  = r_wr_addr;
        n_clr_addr = r_clr_addr;
        n_q_bad    = r_q_bad;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        ram_we    = r_wr_pend;
        ram_waddr = r_wr_addr;
        ram_wdata = cnt_inc;
        ram_raddr = f_addr(LEN_W'(s_qlen), HIST_W'(s_qpat));

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_LEN: n_min_len = i_cfg_wdata;
                CFG_MAX_LEN: n_max_len = i_cfg_wdata;
                default: ;
            endcase
        end

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_mode == MODE_PUSH) begin
                        n_hist   = hist_nx;
                        n_seen   = seen_nx;
                        n_rd_len = LEN_W'(lo_c);
                        n_hi     = LEN_W'(hi_c);
                        if (lo_c <= hi_c) begin
                            n_state = ST_UPD;
                        end
                    end else begin
                        n_q_bad = (qlen_c == '0) || (qlen_c > MAX_LEN_C);
                        n_state = ST_QRD;
                    end
                end
            end
            ST_UPD: begin
                // read one length while the previous length is written back
                ram_raddr = upd_addr;
                n_wr_pend = 1'b1;
                n_wr_addr = upd_addr;
                if (r_rd_len == r_hi) begin
                    n_state = ST_TAIL;
                end else begin
                    n_rd_len = r_rd_len + LEN_W'(1);
                end
            end
            ST_TAIL: begin
                n_state = ST_IDLE;
            end
            ST_QRD: begin
                n_out_vld  = 1'b1;
                n_out_data = r_q_bad ? '0 : OUT_TDATA_W'(ram_rdata);
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_min_len  <= t_len_cfg'(1);
            r_max_len  <= t_len_cfg'(12);
            r_hist     <= '0;
            r_seen     <= '0;
            r_wr_pend  <= 1'b0;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_min_len  <= n_min_len;
            r_max_len  <= n_max_len;
            r_hist     <= n_hist;
            r_seen     <= n_seen;
            r_wr_pend  <= n_wr_pend;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_len   <= n_rd_len;
        r_hi       <= n_hi;
        r_wr_addr  <= n_wr_addr;
        r_q_bad    <= n_q_bad;
        r_out_data <= n_out_data;
    end

    bpfc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

### design/bpfc_ram.sv
// ----------------------------------------------------------------------------
// bpfc_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module bpfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
